// ===== hw/rtl/f2d_pkg.sv =====
// Shared constants, status codes and inter-unit structs of the float-to-decimal text converter.
`default_nettype none

package f2d_pkg;

  localparam int MAX_FRAC_DIGITS = 7;
  localparam int TEXT_LIMIT      = 15;

  localparam int EXP_BIAS  = 127;
  localparam int EXP_MAX   = 31;
  localparam int EXP_MIN   = -23;
  localparam int FRAC_BITS = 24;
  localparam int INT_BITS  = 31;
  localparam int INT_DIGITS = 10;

  localparam int FIX_W     = INT_BITS + FRAC_BITS;
  localparam int SHAMT_MAX = EXP_MAX - 1 - EXP_MIN;
  localparam int SHAMT_W   = $clog2(SHAMT_MAX + 1);
  localparam int WIDE_W    = FRAC_BITS + SHAMT_MAX;

  localparam int ICNT_W    = $clog2(INT_DIGITS + 1);
  localparam int FCNT_W    = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int BIT_CNT_W = $clog2(INT_BITS + 1);

  localparam logic [7:0] EXP_TOO_LARGE = 8'(EXP_BIAS + EXP_MAX);
  localparam logic [7:0] EXP_LOWEST    = 8'(EXP_BIAS + EXP_MIN);

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_NINE  = 7'h39;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_DOT   = 7'h2E;
  localparam logic [6:0] CHAR_NONE  = 7'h00;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_TOO_SMALL = 2'd2;

  typedef struct packed {
    logic start;
    logic shift;
  } unit_cmd_t;

  typedef struct packed {
    logic              done;
    logic [3:0]        top_digit;
    logic [ICNT_W-1:0] ndig;
  } bcd_stat_t;

  typedef struct packed {
    logic                       done;
    logic [3:0]                 digit;
    logic [MAX_FRAC_DIGITS-1:0] nz;
  } frac_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/f2d_bcd.sv =====
// Bit-serial binary to BCD converter for the integer part, with leading-zero removal.
`default_nettype none

module f2d_bcd (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  f2d_pkg::unit_cmd_t            cmd_i,
  input  logic [f2d_pkg::INT_BITS-1:0]  ipart_i,
  output f2d_pkg::bcd_stat_t            stat_o
);
  import f2d_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_NORM, S_DONE} state_e;

  state_e                   state_q, state_d;
  logic [BIT_CNT_W-1:0]     cnt_q, cnt_d;
  logic [ICNT_W-1:0]        ndig_q, ndig_d;
  logic [INT_BITS-1:0]      bin_q, bin_d;
  logic [4*INT_DIGITS-1:0]  bcd_q, bcd_d;
  logic [4*INT_DIGITS-1:0]  adj;

  always_comb begin
    for (int i = 0; i < INT_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ndig_d  = ndig_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    case (state_q)
      S_CONV: begin
        bcd_d = {adj[4*INT_DIGITS-2:0], bin_q[INT_BITS-1]};
        bin_d = bin_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == BIT_CNT_W'(1)) begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (bcd_q[4*INT_DIGITS-1 -: 4] == 4'd0 && ndig_q > ICNT_W'(1)) begin
          bcd_d  = bcd_q << 4;
          ndig_d = ndig_q - 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (cmd_i.shift) begin
          bcd_d = bcd_q << 4;
        end
      end
      default: begin
      end
    endcase
    if (cmd_i.start) begin
      state_d = S_CONV;
      cnt_d   = BIT_CNT_W'(INT_BITS);
      ndig_d  = ICNT_W'(INT_DIGITS);
      bin_d   = ipart_i;
      bcd_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ndig_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ndig_q  <= ndig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign stat_o.done      = (state_q == S_DONE);
  assign stat_o.top_digit = bcd_q[4*INT_DIGITS-1 -: 4];
  assign stat_o.ndig      = ndig_q;

endmodule

`default_nettype wire

// ===== hw/rtl/f2d_frac.sv =====
// Digit-serial fraction unit: one decimal digit per cycle by multiplying the fraction by ten.
`default_nettype none

module f2d_frac (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  f2d_pkg::unit_cmd_t             cmd_i,
  input  logic [f2d_pkg::FRAC_BITS-1:0]  frac_i,
  output f2d_pkg::frac_stat_t            stat_o
);
  import f2d_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_e;

  state_e                     state_q, state_d;
  logic [FCNT_W-1:0]          cnt_q, cnt_d;
  logic [FRAC_BITS-1:0]       frac_q, frac_d;
  logic [3:0]                 dig_q [MAX_FRAC_DIGITS];
  logic [3:0]                 dig_d [MAX_FRAC_DIGITS];
  logic [MAX_FRAC_DIGITS-1:0] nz_q, nz_d;
  logic [FRAC_BITS+3:0]       prod;
  logic [3:0]                 new_digit;
  logic                       do_shift;

  assign prod      = ({4'b0, frac_q} << 3) + ({4'b0, frac_q} << 1);
  assign new_digit = prod[FRAC_BITS+3:FRAC_BITS];
  assign do_shift  = (state_q == S_RUN) || (state_q == S_DONE && cmd_i.shift);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    frac_d  = frac_q;
    nz_d    = nz_q;
    for (int i = 0; i < MAX_FRAC_DIGITS; i++) begin
      dig_d[i] = dig_q[i];
    end
    if (do_shift) begin
      for (int i = 0; i < MAX_FRAC_DIGITS - 1; i++) begin
        dig_d[i] = dig_q[i+1];
      end
      dig_d[MAX_FRAC_DIGITS-1] = (state_q == S_RUN) ? new_digit : 4'd0;
      nz_d = MAX_FRAC_DIGITS'({(state_q == S_RUN) && (new_digit != 4'd0), nz_q} >> 1);
    end
    case (state_q)
      S_RUN: begin
        frac_d = prod[FRAC_BITS-1:0];
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == FCNT_W'(1)) begin
          state_d = S_DONE;
        end
      end
      default: begin
      end
    endcase
    if (cmd_i.start) begin
      state_d = S_RUN;
      cnt_d   = FCNT_W'(MAX_FRAC_DIGITS);
      frac_d  = frac_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frac_q <= frac_d;
    nz_q   <= nz_d;
    for (int i = 0; i < MAX_FRAC_DIGITS; i++) begin
      dig_q[i] <= dig_d[i];
    end
  end

  assign stat_o.done  = (state_q == S_DONE);
  assign stat_o.digit = dig_q[0];
  assign stat_o.nz    = nz_q;

endmodule

`default_nettype wire

// ===== hw/rtl/float32_to_decimal_text_core.sv =====
// An error beat is loaded from the emit state entered when the value is taken; text starts once both units are done.
// The bit-serial binary to BCD loop (31 bits plus up to 9 leading-zero shifts) decides when text starts.
// Throughput: one character per cycle while the sink is ready.
// A new value is taken once the last character has been loaded into the output register.
// Reset clears all control state and the output valid; there is no clearing pass.
`default_nettype none

module float32_to_decimal_text_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  char_code_o,
  output logic        last_o,
  output logic [1:0]  status_o
);
  import f2d_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_e;
  typedef enum logic [2:0] {P_ERR, P_SIGN, P_INT, P_DOT, P_FRAC} phase_e;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic              neg_q, neg_d;
  logic              fzero_q, fzero_d;
  logic [1:0]        err_q, err_d;
  logic [ICNT_W-1:0] icnt_q, icnt_d;
  logic [FCNT_W-1:0] fcnt_q, fcnt_d;
  logic              ovalid_q, ovalid_d;
  logic [6:0]        char_q, char_d;
  logic              last_q, last_d;
  logic [1:0]        status_q, status_d;

  logic [7:0]           exp_f;
  logic                 is_zero, too_large, too_small, accept, step;
  logic [SHAMT_W-1:0]   shamt;
  logic [WIDE_W-1:0]    wide;
  logic [FIX_W-1:0]     fixed;
  logic [INT_BITS-1:0]  ipart;
  logic [FRAC_BITS-1:0] frac;
  logic [FCNT_W-1:0]    nfrac;
  logic                 bshift, fshift;

  unit_cmd_t  bcmd, fcmd;
  bcd_stat_t  bstat;
  frac_stat_t fstat;

  assign exp_f     = value_bits_i[30:23];
  assign is_zero   = (value_bits_i[30:0] == 31'd0);
  assign too_large = (exp_f >= EXP_TOO_LARGE);
  assign too_small = !is_zero && (exp_f < EXP_LOWEST);
  assign shamt     = SHAMT_W'(exp_f - EXP_LOWEST);
  assign wide      = WIDE_W'({1'b1, value_bits_i[22:0]}) << shamt;
  assign fixed     = is_zero ? '0 : wide[WIDE_W-1 -: FIX_W];
  assign ipart     = fixed[FIX_W-1:FRAC_BITS];
  assign frac      = fixed[FRAC_BITS-1:0];

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign step       = (state_q == S_EMIT) && (!ovalid_q || out_ready_i);

  assign bcmd.start = accept && !too_large && !too_small;
  assign bcmd.shift = bshift;
  assign fcmd.start = accept && !too_large && !too_small;
  assign fcmd.shift = fshift;

  f2d_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (bcmd),
    .ipart_i (ipart),
    .stat_o  (bstat)
  );

  f2d_frac u_frac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (fcmd),
    .frac_i (frac),
    .stat_o (fstat)
  );

  always_comb begin
    int pos;
    int budget;
    int lastnz;
    pos    = int'(neg_q) + int'(bstat.ndig) + 1;
    budget = TEXT_LIMIT - 1 - pos;
    if (budget > MAX_FRAC_DIGITS) begin
      budget = MAX_FRAC_DIGITS;
    end
    lastnz = 0;
    for (int i = 0; i < MAX_FRAC_DIGITS; i++) begin
      if (i < budget && fstat.nz[i]) begin
        lastnz = i + 1;
      end
    end
    if (fzero_q) begin
      nfrac = FCNT_W'(1);
    end else if (budget <= 0) begin
      nfrac = '0;
    end else if (lastnz == 0) begin
      nfrac = FCNT_W'(1);
    end else begin
      nfrac = FCNT_W'(lastnz);
    end
  end

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    neg_d    = neg_q;
    fzero_d  = fzero_q;
    err_d    = err_q;
    icnt_d   = icnt_q;
    fcnt_d   = fcnt_q;
    ovalid_d = ovalid_q;
    char_d   = char_q;
    last_d   = last_q;
    status_d = status_q;
    bshift   = 1'b0;
    fshift   = 1'b0;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          neg_d   = value_bits_i[31] && !is_zero;
          fzero_d = (frac == '0);
          if (too_large) begin
            err_d   = ST_TOO_LARGE;
            phase_d = P_ERR;
            state_d = S_EMIT;
          end else if (too_small) begin
            err_d   = ST_TOO_SMALL;
            phase_d = P_ERR;
            state_d = S_EMIT;
          end else begin
            state_d = S_CONV;
          end
        end
      end
      S_CONV: begin
        if (bstat.done && fstat.done) begin
          icnt_d  = bstat.ndig;
          fcnt_d  = nfrac;
          phase_d = neg_q ? P_SIGN : P_INT;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (step) begin
          ovalid_d = 1'b1;
          last_d   = 1'b0;
          status_d = ST_OK;
          case (phase_q)
            P_ERR: begin
              char_d   = CHAR_NONE;
              last_d   = 1'b1;
              status_d = err_q;
              state_d  = S_IDLE;
            end
            P_SIGN: begin
              char_d  = CHAR_MINUS;
              phase_d = P_INT;
            end
            P_INT: begin
              char_d = CHAR_ZERO + {3'b0, bstat.top_digit};
              bshift = 1'b1;
              icnt_d = icnt_q - 1'b1;
              if (icnt_q == ICNT_W'(1)) begin
                phase_d = P_DOT;
              end
            end
            P_DOT: begin
              char_d = CHAR_DOT;
              if (fcnt_q == '0) begin
                last_d  = 1'b1;
                state_d = S_IDLE;
              end else begin
                phase_d = P_FRAC;
              end
            end
            P_FRAC: begin
              char_d = CHAR_ZERO + {3'b0, fstat.digit};
              fshift = 1'b1;
              fcnt_d = fcnt_q - 1'b1;
              if (fcnt_q == FCNT_W'(1)) begin
                last_d  = 1'b1;
                state_d = S_IDLE;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= P_ERR;
      neg_q    <= 1'b0;
      fzero_q  <= 1'b0;
      err_q    <= ST_OK;
      icnt_q   <= '0;
      fcnt_q   <= '0;
      ovalid_q <= 1'b0;
      char_q   <= CHAR_NONE;
      last_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      neg_q    <= neg_d;
      fzero_q  <= fzero_d;
      err_q    <= err_d;
      icnt_q   <= icnt_d;
      fcnt_q   <= fcnt_d;
      ovalid_q <= ovalid_d;
      char_q   <= char_d;
      last_q   <= last_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/f2d_checker.sv =====
// Port-level checker for the float-to-decimal text converter, bound to the top level.
`default_nettype none

module f2d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [6:0]  char_code_o,
  input logic        last_o,
  input logic [1:0]  status_o
);
  import f2d_pkg::*;

  // An error beat is always the sole, final beat of its value and carries no character.
  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_o && char_code_o == CHAR_NONE)
    else $error("error beat is not a lone final beat");

  // Text beats carry only digits, the minus sign or the decimal point.
  a_text_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |->
      (char_code_o >= CHAR_ZERO && char_code_o <= CHAR_NINE) ||
      char_code_o == CHAR_MINUS || char_code_o == CHAR_DOT)
    else $error("unexpected character in text beat");

  // No new value is taken while the text of the current one is still being sent, its last beat apart.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input ready while text is still in flight");

  // A value that has been taken closes the input straight after; it reopens once its last character is loaded.
  a_ready_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready straight after a value was taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(char_code_o) && $stable(last_o) && $stable(status_o))
    else $error("stalled output beat changed");

endmodule

bind float32_to_decimal_text_core f2d_checker u_f2d_checker (.*);

`default_nettype wire
